@@ src/ptd_pkg.sv @@
// Package for the periodic task dispatcher: opcodes, error codes and
// shared constants. No dependencies.
package ptd_pkg;

    localparam int MAX_RESULTS = 8;
    localparam logic [6:0] SLOT_NONE = 7'h7F;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_TICK    = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_HANDLER = 3'd1,
        ERR_FULL      = 3'd2,
        ERR_RANGE     = 3'd3,
        ERR_NO_TASK   = 3'd4,
        ERR_SUSPENDED = 3'd5,
        ERR_RUNNING   = 3'd6
    } error_t;

    // Register byte addresses on the configuration port
    localparam logic [2:0] ADDR_TICK_DEC = 3'd0;

endpackage

@@ src/periodic_task_dispatcher_core.sv @@
// Periodic task dispatcher: task table with create/delete/suspend/resume
// commands and a tick that counts down and dispatches up to MAX_RESULTS ready tasks in priority order.
// Depends on ptd_pkg.
// A command is latched in S_IDLE and its reply is loaded into the output register
// from S_CMD once the output register is free. A tick runs a countdown pass over
// the task memory, then for each dispatched task a priority sweep over the task
// memory and an emit state.
// One item is worked on at a time; the next is accepted once the previous is
// done, while its last result may still wait in the output register.
// Reset (aresetn low, synchronous) empties the table, clears high-water and
// sets the tick decrement to 1. The task memory is not cleared.
module periodic_task_dispatcher_core
    import ptd_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // opcode[2:0], task_id[10:3], period[18:11], priority_req[26:19],
    // has_handler[27], zero fill[31:28]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // is_dispatch[0], ok[1], error_code[4:2], slot[11:5], zero fill[15:12]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {S_IDLE, S_CMD, S_SCAN, S_SEL, S_EMIT} state_t;

    state_t               state_reg;
    logic [7:0]           tick_dec_reg;
    logic [MAX_TASKS-1:0] exists_reg, susp_reg, ready_reg;
    logic [CW-1:0]        hw_reg;
    logic [CW-1:0]        n_ready_reg;
    logic [3:0]           emit_cnt_reg;
    logic [IW:0]          sweep_reg;
    logic                 rd_valid_reg;
    logic [IW-1:0]        rd_slot_reg;
    logic                 best_valid_reg;
    logic [IW-1:0]        best_slot_reg;
    logic [7:0]           best_pri_reg, best_rel_reg;

    // Latched input item
    logic [2:0]           op_reg;
    logic [7:0]           id_reg, period_reg, prio_reg;
    logic                 handler_reg;

    // Output register
    logic                 m_valid_reg, m_last_reg;
    logic [11:0]          m_data_reg;

    // Task memory: {priority, reload, countdown}
    logic [23:0]          mem [MAX_TASKS];
    logic [23:0]          rdata_reg;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [23:0]          mem_wdata;

    logic                 out_free;
    logic                 out_load;
    logic [7:0]           rd_cd, rd_rel, rd_pri, new_cd;
    logic                 rd_active;
    logic                 free_found;
    logic [IW-1:0]        free_idx;
    logic                 hw_full;
    logic                 id_ok;
    logic [IW-1:0]        id_idx;
    logic                 create_ok;
    logic [IW-1:0]        create_idx;
    logic [3:0]           n_cap;
    logic                 sweep_issue;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_data_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_TICK_DEC) ? {24'd0, tick_dec_reg} : 32'd0;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_CMD) || (state_reg == S_EMIT));

    assign rd_cd  = rdata_reg[7:0];
    assign rd_rel = rdata_reg[15:8];
    assign rd_pri = rdata_reg[23:16];
    assign new_cd = (rd_cd >= tick_dec_reg) ? rd_cd - tick_dec_reg : 8'd0;
    assign rd_active = exists_reg[rd_slot_reg] && !susp_reg[rd_slot_reg];
    assign sweep_issue = (32'(sweep_reg) < MAX_TASKS);

    assign hw_full = (32'(hw_reg) >= MAX_TASKS);
    assign id_ok   = (32'(id_reg) < MAX_TASKS);
    assign id_idx  = id_reg[IW-1:0];
    assign n_cap   = (32'(n_ready_reg) > MAX_RESULTS) ? 4'(MAX_RESULTS) : 4'(n_ready_reg);

    // Find the lowest free slot below high-water
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!exists_reg[i] && (i < 32'(hw_reg))) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign create_ok  = handler_reg && (free_found || !hw_full);
    assign create_idx = free_found ? free_idx : hw_reg[IW-1:0];

    // Select the memory write for this cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = create_idx;
        mem_wdata = {prio_reg, period_reg, period_reg};
        unique case (state_reg)
            S_CMD: begin
                mem_we = out_free && (op_reg == OP_CREATE) && create_ok;
            end
            S_SCAN: begin
                mem_we    = rd_valid_reg && rd_active;
                mem_waddr = rd_slot_reg;
                mem_wdata = {rd_pri, rd_rel, new_cd};
            end
            S_EMIT: begin
                mem_we    = out_free;
                mem_waddr = best_slot_reg;
                mem_wdata = {best_pri_reg, best_rel_reg, best_rel_reg};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Task memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[sweep_reg[IW-1:0]];
    end

    // Control sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tick_dec_reg   <= 8'd1;
            exists_reg     <= '0;
            susp_reg       <= '0;
            ready_reg      <= '0;
            hw_reg         <= '0;
            n_ready_reg    <= '0;
            emit_cnt_reg   <= '0;
            sweep_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Configuration write
            if (psel && penable && pwrite && (paddr == ADDR_TICK_DEC)) begin
                tick_dec_reg <= pwdata[7:0];
            end

            // Load a new result, or drop the one taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // Track the read in flight
            rd_valid_reg <= sweep_issue && ((state_reg == S_SCAN) || (state_reg == S_SEL));
            rd_slot_reg  <= sweep_reg[IW-1:0];

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= s_tdata[2:0];
                        id_reg      <= s_tdata[10:3];
                        period_reg  <= s_tdata[18:11];
                        prio_reg    <= s_tdata[26:19];
                        handler_reg <= s_tdata[27];
                        sweep_reg   <= '0;
                        n_ready_reg <= '0;
                        ready_reg   <= '0;
                        emit_cnt_reg <= '0;
                        if (s_tdata[2:0] == OP_TICK) begin
                            state_reg <= S_SCAN;
                        end else if (s_tdata[2:0] > OP_TICK) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_CMD;
                        end
                    end
                end

                S_CMD: begin
                    if (out_free) begin
                        m_last_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                        if (op_reg == OP_CREATE) begin
                            if (!handler_reg) begin
                                m_data_reg <= {SLOT_NONE, ERR_NO_HANDLER, 1'b0, 1'b0};
                            end else if (!create_ok) begin
                                m_data_reg <= {SLOT_NONE, ERR_FULL, 1'b0, 1'b0};
                            end else begin
                                exists_reg[create_idx] <= 1'b1;
                                susp_reg[create_idx]   <= 1'b0;
                                if (!free_found) begin
                                    hw_reg <= hw_reg + 1'b1;
                                end
                                m_data_reg <= {7'(create_idx), ERR_NONE, 1'b1, 1'b0};
                            end
                        end else if (!id_ok) begin
                            m_data_reg <= {SLOT_NONE, ERR_RANGE, 1'b0, 1'b0};
                        end else if (!exists_reg[id_idx]) begin
                            m_data_reg <= {SLOT_NONE, ERR_NO_TASK, 1'b0, 1'b0};
                        end else if (op_reg == OP_DELETE) begin
                            exists_reg[id_idx] <= 1'b0;
                            m_data_reg <= {7'(id_idx), ERR_NONE, 1'b1, 1'b0};
                        end else if (op_reg == OP_SUSPEND) begin
                            if (susp_reg[id_idx]) begin
                                m_data_reg <= {SLOT_NONE, ERR_SUSPENDED, 1'b0, 1'b0};
                            end else begin
                                susp_reg[id_idx] <= 1'b1;
                                m_data_reg <= {7'(id_idx), ERR_NONE, 1'b1, 1'b0};
                            end
                        end else begin
                            if (!susp_reg[id_idx]) begin
                                m_data_reg <= {SLOT_NONE, ERR_RUNNING, 1'b0, 1'b0};
                            end else begin
                                susp_reg[id_idx] <= 1'b0;
                                m_data_reg <= {7'(id_idx), ERR_NONE, 1'b1, 1'b0};
                            end
                        end
                    end
                end

                // Countdown pass: read, subtract, write back, mark ready
                S_SCAN: begin
                    if (sweep_issue) begin
                        sweep_reg    <= sweep_reg + 1'b1;
                    end
                    if (rd_valid_reg && rd_active && (new_cd == 8'd0)) begin
                        ready_reg[rd_slot_reg] <= 1'b1;
                        n_ready_reg <= n_ready_reg + 1'b1;
                    end
                    if (!sweep_issue && !rd_valid_reg) begin
                        sweep_reg      <= '0;
                        best_valid_reg <= 1'b0;
                        state_reg      <= (n_ready_reg == '0) ? S_IDLE : S_SEL;
                    end
                end

                // Priority sweep over ready slots
                S_SEL: begin
                    if (sweep_issue) begin
                        sweep_reg    <= sweep_reg + 1'b1;
                    end
                    if (rd_valid_reg && ready_reg[rd_slot_reg] &&
                        (!best_valid_reg || (rd_pri < best_pri_reg))) begin
                        best_valid_reg <= 1'b1;
                        best_slot_reg  <= rd_slot_reg;
                        best_pri_reg   <= rd_pri;
                        best_rel_reg   <= rd_rel;
                    end
                    if (!sweep_issue && !rd_valid_reg) begin
                        state_reg <= S_EMIT;
                    end
                end

                // Emit the winner and reload its countdown
                S_EMIT: begin
                    if (out_free) begin
                        m_last_reg  <= (emit_cnt_reg + 1'b1 == n_cap);
                        m_data_reg  <= {7'(best_slot_reg), ERR_NONE, 1'b1, 1'b1};
                        ready_reg[best_slot_reg] <= 1'b0;
                        emit_cnt_reg   <= emit_cnt_reg + 1'b1;
                        sweep_reg      <= '0;
                        best_valid_reg <= 1'b0;
                        state_reg <= (emit_cnt_reg + 1'b1 == n_cap) ? S_IDLE : S_SEL;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/ptd_checker.sv @@
// Port-level checker for the periodic task dispatcher, bound to the core module.
// Depends on periodic_task_dispatcher_core ports only.
module ptd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tvalid,
    input logic        m_tready
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Come out of reset with no result pending
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Dispatches always succeed
    a_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1] && (m_tdata[4:2] == 3'd0))
        else $error("dispatch with error");

    // Failed commands carry the no-slot marker and an error code
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] && !m_tdata[1] |->
            (m_tdata[11:5] == 7'h7F) && (m_tdata[4:2] != 3'd0))
        else $error("failed reply malformed");

    // Command replies are single transactions
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tlast)
        else $error("command reply without last");

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

@@ dv/periodic_task_dispatcher_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for periodic_task_dispatcher_core: drives task commands and ticks,
// predicts replies and dispatches, and checks every result transaction.
// Depends on ptd_pkg and the core RTL.
module periodic_task_dispatcher_core_tb;
    import ptd_pkg::*;

    localparam int NTASK = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       is_dispatch;
        logic       ok;
        logic [2:0] error_code;
        logic [6:0] slot;
        logic       last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    periodic_task_dispatcher_core #(.MAX_TASKS(NTASK)) uut (.*);

    always #5 aclk = ~aclk;

    // Scheduler shadow state
    logic [7:0] tick_step;
    logic       shadow_exists [NTASK];
    logic       shadow_susp [NTASK];
    logic [7:0] shadow_count [NTASK];
    logic [7:0] shadow_period [NTASK];
    logic [7:0] shadow_prio [NTASK];
    int         shadow_hwm;

    logic [31:0] pending_cmds[$];
    result_t     expected_results[$];
    int          error_count = 0;
    int          result_count = 0;
    int          dispatch_count = 0;
    int          cycle_count = 0;
    bit          quiet_send = 0;
    bit          quiet_recv = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          recv_hold = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void push_reply(input logic ok, input error_t err, input int s);
        result_t r;
        r.is_dispatch = 1'b0;
        r.ok = ok;
        r.error_code = err;
        r.slot = ok ? 7'(s) : SLOT_NONE;
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Predict results of one accepted command
    function automatic void predict_command(input logic [31:0] w);
        opcode_t op;
        logic [7:0] id;
        int idx;
        int n;
        int best;
        logic ready [NTASK];
        result_t r;
        op = opcode_t'(w[2:0]);
        id = w[10:3];
        idx = -1;
        n = 0;
        if (w[2:0] > 3'd4) return;
        case (op)
            OP_CREATE: begin
                if (!w[27]) begin
                    push_reply(0, ERR_NO_HANDLER, 0);
                    return;
                end
                for (int i = 0; i < shadow_hwm; i++)
                    if (idx < 0 && !shadow_exists[i]) idx = i;
                if (idx < 0) begin
                    if (shadow_hwm >= NTASK) begin
                        push_reply(0, ERR_FULL, 0);
                        return;
                    end
                    idx = shadow_hwm;
                    shadow_hwm++;
                end
                shadow_exists[idx] = 1;
                shadow_susp[idx] = 0;
                shadow_count[idx] = w[18:11];
                shadow_period[idx] = w[18:11];
                shadow_prio[idx] = w[26:19];
                push_reply(1, ERR_NONE, idx);
            end
            OP_TICK: begin
                for (int i = 0; i < NTASK; i++) begin
                    ready[i] = 0;
                    if (i < shadow_hwm && shadow_exists[i] && !shadow_susp[i]) begin
                        shadow_count[i] = (shadow_count[i] >= tick_step) ?
                            shadow_count[i] - tick_step : 8'd0;
                        if (shadow_count[i] == 0) begin
                            ready[i] = 1;
                            n++;
                        end
                    end
                end
                if (n > MAX_RESULTS) n = MAX_RESULTS;
                for (int k = 0; k < n; k++) begin
                    best = -1;
                    for (int i = 0; i < NTASK; i++)
                        if (ready[i] && (best < 0 || shadow_prio[i] < shadow_prio[best]))
                            best = i;
                    ready[best] = 0;
                    shadow_count[best] = shadow_period[best];
                    r.is_dispatch = 1;
                    r.ok = 1;
                    r.error_code = ERR_NONE;
                    r.slot = 7'(best);
                    r.last = (k == n - 1);
                    expected_results.push_back(r);
                end
            end
            default: begin
                if (id >= NTASK) push_reply(0, ERR_RANGE, 0);
                else if (!shadow_exists[id]) push_reply(0, ERR_NO_TASK, 0);
                else if (op == OP_DELETE) begin
                    shadow_exists[id] = 0;
                    push_reply(1, ERR_NONE, id);
                end else if (op == OP_SUSPEND) begin
                    if (shadow_susp[id]) push_reply(0, ERR_SUSPENDED, 0);
                    else begin
                        shadow_susp[id] = 1;
                        push_reply(1, ERR_NONE, id);
                    end
                end else if (!shadow_susp[id]) push_reply(0, ERR_RUNNING, 0);
                else begin
                    shadow_susp[id] = 0;
                    push_reply(1, ERR_NONE, id);
                end
            end
        endcase
    endfunction

    function automatic logic [31:0] pack_cmd(input logic [2:0] op, input logic [7:0] id,
                                             input logic [7:0] per, input logic [7:0] pri,
                                             input logic hnd);
        return {4'b0, hnd, pri, per, id, op};
    endfunction

    // Driver: offer queued commands, idle at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_command(s_tdata);
                void'(pending_cmds.pop_front());
            end
            if ((!s_tvalid || s_tready) || !s_tvalid) begin
                if ((s_tvalid && s_tready) || !s_tvalid) begin
                    if (pending_cmds.size() > (s_tvalid && s_tready ? 0 : 0) &&
                        (quiet_send || $urandom_range(99) >= 35)) begin
                        s_tvalid <= 1'b1;
                        s_tdata <= pending_cmds[0];
                    end else begin
                        s_tvalid <= 1'b0;
                    end
                end
            end
        end
    end

    // Receiver hold-off: count down a long stall once requested
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            recv_hold <= 300;
            hold_done <= 1'b1;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
        end
    end

    // Monitor: compare result transactions, stall at random or on a long hold
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        cycle_count++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[1], m_tdata[4:2], m_tdata[11:5], m_tlast};
                result_count++;
                if (got.is_dispatch) dispatch_count++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else begin
                    want = expected_results.pop_front();
                    if (got.is_dispatch !== want.is_dispatch)
                        report_mismatch($sformatf("is_dispatch %b want %b",
                            got.is_dispatch, want.is_dispatch));
                    if (got.ok !== want.ok)
                        report_mismatch($sformatf("ok %b want %b", got.ok, want.ok));
                    if (got.error_code !== want.error_code)
                        report_mismatch($sformatf("error_code %0d want %0d",
                            got.error_code, want.error_code));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %h want %h", got.slot, want.slot));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b want %b", got.last, want.last));
                end
            end
            if (recv_hold > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_recv || ($urandom_range(99) >= 35);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (NTASK * 12 + 20) @(posedge aclk);
    endtask

    task automatic write_tick_dec(input logic [7:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_TICK_DEC;
        pwdata <= {24'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tick_step = value;
    endtask

    function automatic logic [31:0] random_cmd();
        int pick;
        logic [2:0] op;
        logic [7:0] id;
        pick = $urandom_range(99);
        if (pick < 30) op = OP_CREATE;
        else if (pick < 40) op = OP_DELETE;
        else if (pick < 50) op = OP_SUSPEND;
        else if (pick < 60) op = OP_RESUME;
        else if (pick < 95) op = OP_TICK;
        else op = 3'($urandom_range(5, 7));
        id = ($urandom_range(9) < 8) ? 8'($urandom_range(NTASK - 1)) : 8'($urandom);
        return pack_cmd(op, id, ($urandom_range(3) == 0) ? 8'($urandom) :
                        8'($urandom_range(6)), 8'($urandom_range(255)),
                        $urandom_range(9) != 0);
    endfunction

    initial begin
        logic [7:0] steps [5];
        steps = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd3};
        tick_step = 8'd1;
        shadow_hwm = 0;
        for (int i = 0; i < NTASK; i++) begin
            shadow_exists[i] = 0;
            shadow_susp[i] = 0;
            shadow_count[i] = 0;
            shadow_period[i] = 0;
            shadow_prio[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: errors on empty table, fill, full, reuse, ties, suspend
        pending_cmds.push_back(pack_cmd(OP_CREATE, 8'h00, 8'd1, 8'd5, 1'b0));
        pending_cmds.push_back(pack_cmd(OP_DELETE, 8'hFF, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_SUSPEND, 8'd8, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_RESUME, 8'd7, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(3'd7, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        for (int i = 0; i < NTASK; i++)
            pending_cmds.push_back(pack_cmd(OP_CREATE, 8'd0, (i == 0) ? 8'd255 : 8'd0,
                (i < 2) ? 8'd255 : 8'd3, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_CREATE, 8'd0, 8'd1, 8'd1, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(OP_RESUME, 8'd3, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_SUSPEND, 8'd3, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_SUSPEND, 8'd3, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(OP_RESUME, 8'd3, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_DELETE, 8'd2, 8'd0, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_CREATE, 8'd0, 8'd2, 8'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0));
        wait_drained();

        // Random phases across tick decrement values, with pressure in the first
        for (int p = 0; p < 5; p++) begin
            write_tick_dec(steps[p]);
            quiet_send = (p == 2);
            quiet_recv = (p == 2);
            for (int i = 0; i < 78; i++) pending_cmds.push_back(random_cmd());
            if (p == 0) begin
                @(posedge aclk);
                hold_req = 1'b1;
            end
            if (p == 1) begin
                while (pending_cmds.size() > 40) @(posedge aclk);
                while (expected_results.size() != 0 || s_tvalid) @(posedge aclk);
                repeat (50) @(posedge aclk);
            end
            wait_drained();
        end

        $display("covered %0d results, %0d of them dispatches, over 5 tick decrements",
                 result_count, dispatch_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
